FILE: design/mspwm_pkg.sv
package mspwm_pkg;

    localparam int CHANNELS   = 32;
    localparam int COUNT_BITS = 16;
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IN_BITS    = 16;
    localparam int CHSEL_BITS = 5;
    localparam int PIN_BITS   = 32;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [CH_BITS-1:0]    CH_LAST = CH_BITS'(CHANNELS - 1);

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_START = 2'd1;
    localparam t_kind KIND_WRITE = 2'd2;
    localparam t_kind KIND_STOP  = 2'd3;

    typedef struct packed {
        logic [COUNT_BITS-1:0] period;
        logic [COUNT_BITS-1:0] duty;
        logic [COUNT_BITS-1:0] latch;
        logic [COUNT_BITS-1:0] phase;
    } t_chan;

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [IN_BITS-1:0] v);
        logic [32:0] wide;
        logic [32:0] lim;
        wide = 33'(v);
        lim  = 33'(CNT_MAX);
        if (wide > lim) begin
            return CNT_MAX;
        end
        return COUNT_BITS'(v);
    endfunction

    function automatic logic [COUNT_BITS-1:0] min_count(input logic [COUNT_BITS-1:0] a,
                                                        input logic [COUNT_BITS-1:0] b);
        return (a > b) ? b : a;
    endfunction

    function automatic logic [CH_BITS-1:0] chan_index(input logic [CHSEL_BITS-1:0] c);
        return CH_BITS'(32'(c) % CHANNELS);
    endfunction

endpackage

FILE: design/multichannel_soft_pwm.sv
// A start, write or stop beat passes through S_EXEC and S_DONE, then its result is
// registered on the output. A tick beat walks every channel entry of the state memory,
// one per cycle, in S_TICK, then passes through S_DONE to the output register.
// One beat in work at a time: a new beat is taken only in S_IDLE, once the last has
// left S_DONE, which holds while the output stalls; the next is taken while a result waits.
// Reset clears all channels at once through per-entry valid bits, with no clearing pass.
module multichannel_soft_pwm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_kind,
    input  logic [mspwm_pkg::CHSEL_BITS-1:0]  i_channel,
    input  logic [mspwm_pkg::IN_BITS-1:0]     i_duty_ticks,
    input  logic [mspwm_pkg::IN_BITS-1:0]     i_period_ticks,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mspwm_pkg::PIN_BITS-1:0]    o_pin_levels,
    output logic                              o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_DONE
    } t_state;

    t_state                                r_state;
    mspwm_pkg::t_kind                      r_kind;
    logic [mspwm_pkg::CH_BITS-1:0]         r_ch;
    logic [mspwm_pkg::CH_BITS-1:0]         r_idx;
    logic [mspwm_pkg::COUNT_BITS-1:0]      r_duty;
    logic [mspwm_pkg::COUNT_BITS-1:0]      r_period;
    logic                                  r_status;
    logic [mspwm_pkg::CHANNELS-1:0]        r_level;
    logic [mspwm_pkg::CHANNELS-1:0]        r_vld;
    logic                                  r_out_valid;
    logic                                  r_out_status;
    logic [mspwm_pkg::CHANNELS-1:0]        r_out_level;

    mspwm_pkg::t_chan                      r_mem [mspwm_pkg::CHANNELS];
    mspwm_pkg::t_chan                      r_rdata;
    logic                                  r_rd_vld;

    logic                                  w_in_acc;
    logic [mspwm_pkg::CH_BITS-1:0]         w_rd_addr;
    logic [mspwm_pkg::CH_BITS-1:0]         w_wr_addr;
    logic                                  w_we;
    mspwm_pkg::t_chan                      w_ent;
    mspwm_pkg::t_chan                      n_ent;
    logic                                  n_lvl_bit;
    logic                                  n_lvl_touch;
    logic                                  n_status;
    logic [mspwm_pkg::COUNT_BITS:0]        w_phase_inc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_we       = (r_state == S_EXEC) || (r_state == S_TICK);
    assign w_wr_addr  = (r_state == S_TICK) ? r_idx : r_ch;
    assign w_ent      = r_rd_vld ? r_rdata : '0;

    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_rd_addr = (i_kind == mspwm_pkg::KIND_TICK) ? '0
                          : mspwm_pkg::chan_index(i_channel);
            end
            S_TICK: begin
                w_rd_addr = mspwm_pkg::CH_BITS'(r_idx + 1'b1);
            end
            default: begin
                w_rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        n_ent       = w_ent;
        n_lvl_bit   = 1'b0;
        n_lvl_touch = 1'b0;
        n_status    = 1'b0;
        w_phase_inc = {1'b0, w_ent.phase} + 1'b1;
        case (r_kind)
            mspwm_pkg::KIND_TICK: begin
                if (w_ent.period != '0) begin
                    if (w_ent.phase == '0) begin
                        n_ent.latch = w_ent.duty;
                    end
                    n_lvl_touch = 1'b1;
                    n_lvl_bit   = (w_ent.phase < n_ent.latch);
                    if (w_phase_inc >= {1'b0, w_ent.period}) begin
                        n_ent.phase = '0;
                    end else begin
                        n_ent.phase = w_phase_inc[mspwm_pkg::COUNT_BITS-1:0];
                    end
                end
            end
            mspwm_pkg::KIND_START: begin
                if (w_ent.period != '0 || r_period == '0) begin
                    n_status = 1'b1;
                end else begin
                    n_ent.period = r_period;
                    n_ent.duty   = mspwm_pkg::min_count(r_duty, r_period);
                    n_ent.latch  = '0;
                    n_ent.phase  = '0;
                    n_lvl_touch  = 1'b1;
                end
            end
            mspwm_pkg::KIND_WRITE: begin
                n_ent.duty = mspwm_pkg::min_count(r_duty, w_ent.period);
            end
            default: begin
                if (w_ent.period != '0) begin
                    n_ent.period = '0;
                    n_ent.phase  = '0;
                    n_ent.latch  = '0;
                    n_lvl_touch  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata  <= r_mem[w_rd_addr];
        r_rd_vld <= r_vld[w_rd_addr];
        if (w_we) begin
            r_mem[w_wr_addr] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kind       <= mspwm_pkg::KIND_TICK;
            r_ch         <= '0;
            r_idx        <= '0;
            r_duty       <= '0;
            r_period     <= '0;
            r_status     <= 1'b0;
            r_level      <= '0;
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= 1'b0;
            r_out_level  <= '0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_vld[w_wr_addr] <= 1'b1;
                if (n_lvl_touch) begin
                    r_level[w_wr_addr] <= n_lvl_bit;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind   <= i_kind;
                        r_ch     <= mspwm_pkg::chan_index(i_channel);
                        r_duty   <= mspwm_pkg::sat_count(i_duty_ticks);
                        r_period <= mspwm_pkg::sat_count(i_period_ticks);
                        r_idx    <= '0;
                        r_state  <= (i_kind == mspwm_pkg::KIND_TICK) ? S_TICK : S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= n_status;
                    r_state  <= S_DONE;
                end
                S_TICK: begin
                    r_status <= 1'b0;
                    r_idx    <= mspwm_pkg::CH_BITS'(r_idx + 1'b1);
                    if (r_idx == mspwm_pkg::CH_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_status <= r_status;
                        r_out_level  <= r_level;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

    for (genvar g = 0; g < mspwm_pkg::PIN_BITS; g++) begin : g_pins
        if (g < mspwm_pkg::CHANNELS) begin : g_on
            assign o_pin_levels[g] = r_out_level[g];
        end else begin : g_off
            assign o_pin_levels[g] = 1'b0;
        end
    end

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind == mspwm_pkg::KIND_TICK) |=> (r_state == S_TICK && r_idx == '0))
        else $error("tick beat did not start the channel walk at entry zero");

    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && r_idx == mspwm_pkg::CH_LAST) |=> (r_state == S_DONE))
        else $error("channel walk did not finish after the last entry");

    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DONE))
        else $error("single channel beat took more than one update cycle");

    a_stop_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_kind == mspwm_pkg::KIND_STOP) |=> !r_level[$past(r_ch)])
        else $error("stopped channel pin is not low");

endmodule

FILE: tb/sv/tb_multichannel_soft_pwm.sv
`timescale 1ns / 1ps

module tb_multichannel_soft_pwm;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BEATS = 1524;

    typedef struct {
        logic [mspwm_pkg::PIN_BITS-1:0] pins;
        logic                           status;
    } t_pwm_result;

    class pwm_scoreboard;
        logic [mspwm_pkg::COUNT_BITS-1:0] duty_by_ch [mspwm_pkg::CHANNELS];
        logic [mspwm_pkg::COUNT_BITS-1:0] period_by_ch [mspwm_pkg::CHANNELS];
        logic [mspwm_pkg::COUNT_BITS-1:0] latch_by_ch [mspwm_pkg::CHANNELS];
        logic [mspwm_pkg::COUNT_BITS-1:0] phase_by_ch [mspwm_pkg::CHANNELS];
        logic [mspwm_pkg::CHANNELS-1:0]   levels;
        t_pwm_result                      levels_due [$];
        int errors, checked, beats, ticks, starts, rejects, writes, stops;

        function new();
            for (int c = 0; c < mspwm_pkg::CHANNELS; c++) begin
                duty_by_ch[c] = '0;
                period_by_ch[c] = '0;
                latch_by_ch[c] = '0;
                phase_by_ch[c] = '0;
            end
            levels = '0;
            errors = 0;
            checked = 0;
            beats = 0;
            ticks = 0;
            starts = 0;
            rejects = 0;
            writes = 0;
            stops = 0;
        endfunction

        function void note_beat(mspwm_pkg::t_kind kind,
                                logic [mspwm_pkg::CHSEL_BITS-1:0] ch_sel,
                                logic [mspwm_pkg::IN_BITS-1:0] duty_in,
                                logic [mspwm_pkg::IN_BITS-1:0] period_in);
            int ch;
            logic [mspwm_pkg::COUNT_BITS-1:0] duty;
            logic [mspwm_pkg::COUNT_BITS-1:0] period;
            t_pwm_result res;
            ch = int'(ch_sel) % mspwm_pkg::CHANNELS;
            duty = (64'(duty_in) > 64'(mspwm_pkg::CNT_MAX)) ? mspwm_pkg::CNT_MAX
                 : mspwm_pkg::COUNT_BITS'(duty_in);
            period = (64'(period_in) > 64'(mspwm_pkg::CNT_MAX)) ? mspwm_pkg::CNT_MAX
                   : mspwm_pkg::COUNT_BITS'(period_in);
            res.status = 1'b0;
            beats++;
            case (kind)
                mspwm_pkg::KIND_TICK: begin
                    ticks++;
                    for (int c = 0; c < mspwm_pkg::CHANNELS; c++) begin
                        if (period_by_ch[c] != '0) begin
                            if (phase_by_ch[c] == '0) begin
                                latch_by_ch[c] = duty_by_ch[c];
                            end
                            levels[c] = (phase_by_ch[c] < latch_by_ch[c]);
                            if (64'(phase_by_ch[c]) + 1 >= 64'(period_by_ch[c])) begin
                                phase_by_ch[c] = '0;
                            end else begin
                                phase_by_ch[c] = phase_by_ch[c] + 1'b1;
                            end
                        end
                    end
                end
                mspwm_pkg::KIND_START: begin
                    starts++;
                    if (period_by_ch[ch] != '0 || period == '0) begin
                        res.status = 1'b1;
                        rejects++;
                    end else begin
                        period_by_ch[ch] = period;
                        duty_by_ch[ch] = (duty > period) ? period : duty;
                        latch_by_ch[ch] = '0;
                        phase_by_ch[ch] = '0;
                        levels[ch] = 1'b0;
                    end
                end
                mspwm_pkg::KIND_WRITE: begin
                    writes++;
                    duty_by_ch[ch] = (duty > period_by_ch[ch]) ? period_by_ch[ch] : duty;
                end
                default: begin
                    stops++;
                    if (period_by_ch[ch] != '0) begin
                        period_by_ch[ch] = '0;
                        phase_by_ch[ch] = '0;
                        latch_by_ch[ch] = '0;
                        levels[ch] = 1'b0;
                    end
                end
            endcase
            res.pins = mspwm_pkg::PIN_BITS'(levels);
            levels_due.push_back(res);
        endfunction

        function void flag(string what, t_pwm_result want,
                           logic [mspwm_pkg::PIN_BITS-1:0] pins, logic st);
            errors++;
            if (errors <= 10) begin
                $display("%0t: %s: expected pins %h status %0d, got pins %h status %0d",
                         $time, what, want.pins, want.status, pins, st);
            end
        endfunction

        function void check_result(logic [mspwm_pkg::PIN_BITS-1:0] pins, logic st);
            t_pwm_result want;
            if (levels_due.size() == 0) begin
                want.pins = 'x;
                want.status = 1'bx;
                flag("result with nothing outstanding", want, pins, st);
            end else begin
                want = levels_due.pop_front();
                checked++;
                if (pins !== want.pins || st !== want.status) begin
                    flag("mismatch", want, pins, st);
                end
            end
        endfunction

        function int pending();
            return levels_due.size();
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    mspwm_pkg::t_kind                 i_kind = mspwm_pkg::KIND_TICK;
    logic [mspwm_pkg::CHSEL_BITS-1:0] i_channel = '0;
    logic [mspwm_pkg::IN_BITS-1:0]    i_duty_ticks = '0;
    logic [mspwm_pkg::IN_BITS-1:0]    i_period_ticks = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [mspwm_pkg::PIN_BITS-1:0]   o_pin_levels;
    logic                             o_status;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;
    pwm_scoreboard sb = new();

    multichannel_soft_pwm dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_duty_ticks   (i_duty_ticks),
        .i_period_ticks (i_period_ticks),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pin_levels   (o_pin_levels),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_beat(i_kind, i_channel, i_duty_ticks, i_period_ticks);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_pin_levels, o_status);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_beat(input mspwm_pkg::t_kind kind,
                             input logic [mspwm_pkg::CHSEL_BITS-1:0] ch,
                             input logic [mspwm_pkg::IN_BITS-1:0] duty,
                             input logic [mspwm_pkg::IN_BITS-1:0] period);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_channel <= ch;
        i_duty_ticks <= duty;
        i_period_ticks <= period;
        do @(posedge i_clk); while (!o_in_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_random(input int count);
        int pick;
        mspwm_pkg::t_kind kind;
        logic [mspwm_pkg::CHSEL_BITS-1:0] ch;
        logic [mspwm_pkg::IN_BITS-1:0] duty;
        logic [mspwm_pkg::IN_BITS-1:0] period;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                kind = mspwm_pkg::KIND_TICK;
            end else if (pick < 68) begin
                kind = mspwm_pkg::KIND_START;
            end else if (pick < 88) begin
                kind = mspwm_pkg::KIND_WRITE;
            end else begin
                kind = mspwm_pkg::KIND_STOP;
            end
            ch = $urandom_range(1) ? mspwm_pkg::CHSEL_BITS'($urandom_range(3))
                                   : mspwm_pkg::CHSEL_BITS'($urandom_range(31));
            case ($urandom_range(9))
                0: period = '0;
                1: period = 16'hFFFF - mspwm_pkg::IN_BITS'($urandom_range(1));
                2: period = mspwm_pkg::IN_BITS'($urandom_range(65535));
                default: period = mspwm_pkg::IN_BITS'($urandom_range(8, 1));
            endcase
            case ($urandom_range(9))
                0: duty = 16'hFFFF;
                1: duty = mspwm_pkg::IN_BITS'($urandom_range(65535));
                default: duty = mspwm_pkg::IN_BITS'($urandom_range(9));
            endcase
            send_beat(kind, ch, duty, period);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(mspwm_pkg::KIND_TICK, 5'd0, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_START, 5'd0, 16'd5, 16'h0000);
        send_beat(mspwm_pkg::KIND_START, 5'd0, 16'hFFFF, 16'd3);
        send_beat(mspwm_pkg::KIND_START, 5'd0, 16'd1, 16'd5);
        send_beat(mspwm_pkg::KIND_START, 5'd31, 16'h8000, 16'hFFFF);
        send_beat(mspwm_pkg::KIND_WRITE, 5'd5, 16'hFFFF, 16'h0000);
        send_beat(mspwm_pkg::KIND_START, 5'd1, 16'd1, 16'd1);
        send_beat(mspwm_pkg::KIND_TICK, 5'd31, 16'hFFFF, 16'hFFFF);
        send_beat(mspwm_pkg::KIND_TICK, 5'd0, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_WRITE, 5'd0, 16'd1, 16'h0000);
        repeat (4) send_beat(mspwm_pkg::KIND_TICK, 5'd0, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_STOP, 5'd0, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_STOP, 5'd0, 16'hFFFF, 16'hFFFF);
        send_beat(mspwm_pkg::KIND_TICK, 5'd0, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_WRITE, 5'd31, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_START, 5'd2, 16'd1, 16'd2);
        repeat (3) send_beat(mspwm_pkg::KIND_TICK, 5'd0, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_STOP, 5'd31, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_STOP, 5'd1, 16'h0000, 16'h0000);
        send_beat(mspwm_pkg::KIND_STOP, 5'd2, 16'h0000, 16'h0000);

        send_idle_pct = 6;
        recv_idle_pct = 76;
        send_random(RANDOM_BEATS / 3);
        send_idle_pct = 76;
        recv_idle_pct = 6;
        send_random(RANDOM_BEATS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (mspwm_pkg::CHANNELS + 8) @(posedge i_clk);

        $display("Sent %0d beats: %0d ticks, %0d starts (%0d rejected), %0d writes, %0d stops.",
                 sb.beats, sb.ticks, sb.starts, sb.rejects, sb.writes, sb.stops);
        $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
                 sb.checked, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
